/* rtl/ptts_pkg.sv */
// ptts_pkg: shared types and codes for the periodic task tick scheduler
// request and status codes, field widths and sequencer state type
// no dependencies
package ptts_pkg;

	// field widths
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned MASK_W   = 8;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 3'd0,
		REQ_CREATE = 3'd1,
		REQ_DELETE = 3'd2,
		REQ_PLAY   = 3'd3,
		REQ_PAUSE  = 3'd4
	} req_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_USED  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_TICK = 2'd1,
		S_DONE = 2'd2
	} state_t;

endpackage

/* rtl/ptts_slot_ram.sv */
// ptts_slot_ram: per-slot period and countdown table
// one write port, one read port with registered read data; uses ptts_pkg widths
module ptts_slot_ram
	import ptts_pkg::*;
#(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [2*TIME_W-1:0]   wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [2*TIME_W-1:0]   rd_data
);

	// word: countdown in the upper half, period in the lower half
	logic [2*TIME_W-1:0] mem_q [DEPTH];
	logic [2*TIME_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/periodic_task_tick_scheduler.sv */
// periodic_task_tick_scheduler: top level of the time-triggered task scheduler
// holds slot marks, the request sequencer and the shared countdown decrementer
// depends on ptts_pkg and ptts_slot_ram

// One request is taken at a time and gives exactly one result. Create,
// delete, play, pause and unused codes pass from the input transfer
// through S_DONE to m_axis_tvalid; a tick first passes through S_TICK,
// where it walks the slot table one slot per cycle through the single read
// port of the period/countdown memory and one shared 16-bit decrementer.
// s_axis_tready is high only while no request is in progress, so a new
// request is taken only once the last one has put its result into the
// output register. The result sits in an output register, so the next
// request may be taken while that result still waits; a stalled result
// register holds the following request until it frees up.
// Slots beyond the eighth are scheduled but have no bit in fired_mask.
module periodic_task_tick_scheduler
	import ptts_pkg::*;
#(
	parameter int unsigned SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] slot_index, [23:8] period_value, [39:24] first_delay,
	// [40] start_running, [47:41] zero
	input  logic [47:0] s_axis_tdata,
	// [2:0] req_type
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [9:2] fired_mask, [15:10] zero
	output logic [15:0] m_axis_tdata
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// request fields
	logic [REQ_W-1:0]  req_type;
	logic [IDX_W-1:0]  slot_index;
	logic [TIME_W-1:0] period_value;
	logic [TIME_W-1:0] first_delay;
	logic              start_running;
	logic [AW-1:0]     req_addr;
	logic              in_range;
	logic              accept;

	assign req_type      = s_axis_tuser;
	assign slot_index    = s_axis_tdata[7:0];
	assign period_value  = s_axis_tdata[23:8];
	assign first_delay   = s_axis_tdata[39:24];
	assign start_running = s_axis_tdata[40];
	assign req_addr      = slot_index[AW-1:0];
	assign in_range      = (slot_index < IDX_W'(SLOTS));

	// control state
	state_t             state_q, state_d;
	logic [SLOTS-1:0]   slot_used_q;
	logic [SLOTS-1:0]   slot_running_q;
	logic [AW-1:0]      slot_q;
	logic [MASK_W-1:0]  mask_q;
	status_t            status_q;
	logic               m_valid_q;
	logic [15:0]        m_data_q;
	logic               out_free;
	logic               last_slot;
	status_t            cmd_status;

	// memory port signals
	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	logic [2*TIME_W-1:0] ram_wr_data;
	logic                ram_rd_en;
	logic [AW-1:0]       ram_rd_addr;
	logic [2*TIME_W-1:0] ram_rd_data;

	// shared decrementer
	logic [TIME_W-1:0] cur_period;
	logic [TIME_W-1:0] cur_count;
	logic              count_zero;
	logic [TIME_W-1:0] dec_operand;
	logic [TIME_W-1:0] dec_result;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign last_slot     = (slot_q == AW'(SLOTS - 1));

	ptts_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// reload on zero, otherwise count down: one subtractor serves both
	assign cur_period  = ram_rd_data[TIME_W-1:0];
	assign cur_count   = ram_rd_data[2*TIME_W-1:TIME_W];
	assign count_zero  = (cur_count == '0);
	assign dec_operand = count_zero ? cur_period : cur_count;
	assign dec_result  = dec_operand - TIME_W'(1);

	// status of a slot request
	always_comb begin
		cmd_status = ST_OK;
		case (req_type)
			REQ_CREATE: begin
				if (!in_range) cmd_status = ST_RANGE;
				else if (slot_used_q[req_addr]) cmd_status = ST_USED;
			end
			REQ_DELETE, REQ_PLAY, REQ_PAUSE: begin
				if (!in_range) cmd_status = ST_RANGE;
				else if (!slot_used_q[req_addr]) cmd_status = ST_EMPTY;
			end
			default: cmd_status = ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (req_type == REQ_TICK) ? S_TICK : S_DONE;
			end
			S_TICK: begin
				if (last_slot) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port drive
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_rd_en   = accept && (req_type == REQ_TICK);
				ram_wr_en   = accept && (req_type == REQ_CREATE) && (cmd_status == ST_OK);
				ram_wr_addr = req_addr;
				ram_wr_data = {first_delay, period_value};
			end
			S_TICK: begin
				ram_rd_en   = !last_slot;
				ram_rd_addr = slot_q + AW'(1);
				ram_wr_en   = slot_used_q[slot_q];
				ram_wr_addr = slot_q;
				ram_wr_data = {dec_result, cur_period};
			end
			default: begin
				ram_rd_en = 1'b0;
			end
		endcase
	end

	// sequencer and slot marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slot_used_q    <= '0;
			slot_running_q <= '0;
			slot_q         <= '0;
			mask_q         <= '0;
			status_q       <= ST_OK;
		end else begin
			state_q <= state_d;
			if (accept) begin
				slot_q   <= '0;
				mask_q   <= '0;
				status_q <= cmd_status;
				if (cmd_status == ST_OK && in_range) begin
					case (req_type)
						REQ_CREATE: begin
							slot_used_q[req_addr]    <= 1'b1;
							slot_running_q[req_addr] <= start_running;
						end
						REQ_DELETE: begin
							slot_used_q[req_addr]    <= 1'b0;
							slot_running_q[req_addr] <= 1'b0;
						end
						REQ_PLAY:  slot_running_q[req_addr] <= 1'b1;
						REQ_PAUSE: slot_running_q[req_addr] <= 1'b0;
						default: ;
					endcase
				end
			end else if (state_q == S_TICK) begin
				slot_q <= slot_q + AW'(1);
				if (slot_used_q[slot_q] && count_zero && slot_running_q[slot_q]) begin
					mask_q <= mask_q | (MASK_W'(1) << slot_q);
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_data_q <= {6'b0, mask_q, status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// read and write ports never meet on one slot
	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
		else $error("slot table read and write collide");

	// the tick walk never passes the last slot
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK) |-> (slot_q <= AW'(SLOTS - 1)))
		else $error("tick walk out of range");

	// a successful create marks its slot occupied
	a_create_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && state_q == S_IDLE) |=> slot_used_q[$past(req_addr)])
		else $error("created slot not marked occupied");

	// a result other than a tick carries no fired slots
	a_mask_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type != REQ_TICK) |=> (mask_q == '0))
		else $error("fired mask set outside a tick");

endmodule
